// File: rtl/core/ctrb_pkg.sv
// Shared types and constants for the clipped tile rectangle blit row generator.
`default_nettype none
package ctrb_pkg;

	localparam int DEST_COLS_DEF = 32;
	localparam int DEST_ROWS_DEF = 24;
	// upper end of the supported destination size range
	localparam int DEST_MAX      = 64;
	localparam int ROWS_W        = $clog2(DEST_MAX + 1);
	localparam int QUEUE_DEPTH   = 2;

	localparam int SRC_W = 18;
	localparam int DST_W = 10;
	localparam int LEN_W = 6;
	localparam int BUF_W = 3;
	localparam int MSK_W = 8;

	// one clipped, non-empty rectangle ready for row expansion
	typedef struct packed {
		logic              mode;
		logic [SRC_W-1:0]  src_base;
		logic [7:0]        map_cols;
		logic [DST_W-1:0]  dst_base;
		logic [LEN_W-1:0]  run_length;
		logic [ROWS_W-1:0] rows;
		logic [BUF_W-1:0]  buffer;
		logic [MSK_W-1:0]  dirty;
	} desc_t;

endpackage
`default_nettype wire

// File: rtl/core/ctrb_req_if.sv
// Request channel: one tile rectangle per transaction.
`default_nettype none
interface ctrb_req_if;
	logic              valid;
	logic              ready;
	logic              mode;
	logic signed [8:0] dest_col;
	logic signed [8:0] dest_row;
	logic [7:0]        src_col;
	logic [7:0]        src_row;
	logic signed [8:0] req_cols;
	logic signed [8:0] req_rows;
	logic [7:0]        map_cols;
	logic [7:0]        map_rows;
	logic [2:0]        buffer_index;

	modport source (output valid, mode, dest_col, dest_row, src_col, src_row, req_cols,
		req_rows, map_cols, map_rows, buffer_index, input ready);
	modport sink (input valid, mode, dest_col, dest_row, src_col, src_row, req_cols,
		req_rows, map_cols, map_rows, buffer_index, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ctrb_cmd_if.sv
// Row command channel: one row move per transaction.
`default_nettype none
interface ctrb_cmd_if;
	logic        valid;
	logic        ready;
	logic [17:0] src_offset;
	logic [9:0]  dst_offset;
	logic [5:0]  run_length;
	logic        row_mode;
	logic [2:0]  target_buffer;
	logic [7:0]  dirty_mask;
	logic        last_row;

	modport source (output valid, src_offset, dst_offset, run_length, row_mode,
		target_buffer, dirty_mask, last_row, input ready);
	modport sink (input valid, src_offset, dst_offset, run_length, row_mode,
		target_buffer, dirty_mask, last_row, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ctrb_front.sv
// Front end: request intake, clipping, dirty mask and descriptor build.
`default_nettype none
module ctrb_front
	import ctrb_pkg::*;
#(
	parameter int DEST_COLS = DEST_COLS_DEF,
	parameter int DEST_ROWS = DEST_ROWS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ctrb_req_if.sink    req,
	output desc_t       push_desc,
	output logic        push_valid,
	input  wire logic   push_ready
);

	localparam logic signed [10:0] COLS_S = 11'(DEST_COLS);
	localparam logic signed [10:0] ROWS_S = 11'(DEST_ROWS);

	logic signed [10:0] dcol, drow, w0, h0, w1, h1, x0, y0, w2, h2;
	logic [9:0]         scol0, srow0;
	logic               nonempty, accept;
	logic [MSK_W-1:0]   dirty_q, dirty_next;

	logic               valid_s1;
	logic               mode_s1;
	logic [7:0]         x_s1, y_s1, mcols_s1;
	logic [9:0]         scol_s1, srow_s1;
	logic [LEN_W-1:0]   w_s1;
	logic [ROWS_W-1:0]  h_s1;
	logic [BUF_W-1:0]   buf_s1;
	logic [MSK_W-1:0]   dirty_s1;
	logic [17:0]        prod;

	// clip against the destination
	always_comb begin
		dcol = {{2{req.dest_col[8]}}, req.dest_col};
		drow = {{2{req.dest_row[8]}}, req.dest_row};
		w0 = (req.req_cols == -9'sd1) ? {3'b000, req.map_cols}
			: {{2{req.req_cols[8]}}, req.req_cols};
		h0 = (req.req_rows == -9'sd1) ? {3'b000, req.map_rows}
			: {{2{req.req_rows[8]}}, req.req_rows};
		if (dcol < 11'sd0) begin
			scol0 = 10'(req.src_col) + 10'(-dcol);
			w1    = w0 + dcol;
			x0    = 11'sd0;
		end else begin
			scol0 = 10'(req.src_col);
			w1    = w0;
			x0    = dcol;
		end
		if (drow < 11'sd0) begin
			srow0 = 10'(req.src_row) + 10'(-drow);
			h1    = h0 + drow;
			y0    = 11'sd0;
		end else begin
			srow0 = 10'(req.src_row);
			h1    = h0;
			y0    = drow;
		end
		w2 = (x0 + w1 > COLS_S) ? COLS_S - x0 : w1;
		h2 = (y0 + h1 > ROWS_S) ? ROWS_S - y0 : h1;
		nonempty = (w2 > 11'sd0) && (h2 > 11'sd0);
	end

	assign req.ready  = !valid_s1 || push_ready;
	assign accept     = req.valid && req.ready;
	assign dirty_next = dirty_q | (MSK_W'(1) << req.buffer_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				dirty_q  <= dirty_next;
				valid_s1 <= nonempty;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= req.mode;
			x_s1     <= x0[7:0];
			y_s1     <= y0[7:0];
			w_s1     <= w2[LEN_W-1:0];
			h_s1     <= h2[ROWS_W-1:0];
			scol_s1  <= scol0;
			srow_s1  <= srow0;
			mcols_s1 <= req.map_cols;
			buf_s1   <= req.buffer_index;
			dirty_s1 <= dirty_next;
		end
	end

	// row base of the first source row
	assign prod = 18'(mcols_s1) * 18'(srow_s1);

	always_comb begin
		push_desc.mode       = mode_s1;
		push_desc.src_base   = prod + 18'(scol_s1);
		push_desc.map_cols   = mcols_s1;
		push_desc.dst_base   = DST_W'(int'(x_s1) + int'(y_s1) * DEST_COLS);
		push_desc.run_length = w_s1;
		push_desc.rows       = h_s1;
		push_desc.buffer     = buf_s1;
		push_desc.dirty      = dirty_s1;
	end

	assign push_valid = valid_s1;

endmodule
`default_nettype wire

// File: rtl/core/ctrb_queue.sv
// Small descriptor FIFO between front and back ends.
`default_nettype none
module ctrb_queue
	import ctrb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire desc_t  push_desc,
	input  wire logic   push_valid,
	output logic        push_ready,
	output desc_t       pop_desc,
	output logic        pop_valid,
	input  wire logic   pop_ready
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	desc_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_desc   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)      count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_desc;
	end

endmodule
`default_nettype wire

// File: rtl/core/ctrb_back.sv
// Back end: expands a descriptor into one row command per cycle while cmd is ready.
`default_nettype none
module ctrb_back
	import ctrb_pkg::*;
#(
	parameter int DEST_COLS = DEST_COLS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire desc_t  pop_desc,
	input  wire logic   pop_valid,
	output logic        pop_ready,
	ctrb_cmd_if.source  cmd
);

	logic              busy_q;
	logic [ROWS_W-1:0] rows_q;
	logic [SRC_W-1:0]  src_q;
	logic [DST_W-1:0]  dst_q;
	logic              mode_q;
	logic [7:0]        mcols_q;
	logic [LEN_W-1:0]  len_q;
	logic [BUF_W-1:0]  buf_q;
	logic [MSK_W-1:0]  dirty_q;
	logic              fire, last, load;

	assign fire      = busy_q && cmd.ready;
	assign last      = rows_q == ROWS_W'(1);
	assign pop_ready = !busy_q || (fire && last);
	assign load      = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rows_q <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				rows_q <= pop_desc.rows;
			end else if (fire) begin
				if (last) busy_q <= 1'b0;
				rows_q <= rows_q - ROWS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			src_q   <= pop_desc.src_base;
			dst_q   <= pop_desc.dst_base;
			mode_q  <= pop_desc.mode;
			mcols_q <= pop_desc.map_cols;
			len_q   <= pop_desc.run_length;
			buf_q   <= pop_desc.buffer;
			dirty_q <= pop_desc.dirty;
		end else if (fire) begin
			src_q <= src_q + SRC_W'(mcols_q);
			dst_q <= dst_q + DST_W'(DEST_COLS);
		end
	end

	assign cmd.valid         = busy_q;
	assign cmd.src_offset    = mode_q ? src_q : '0;
	assign cmd.dst_offset    = dst_q;
	assign cmd.run_length    = len_q;
	assign cmd.row_mode      = mode_q;
	assign cmd.target_buffer = buf_q;
	assign cmd.dirty_mask    = dirty_q;
	assign cmd.last_row      = last;

endmodule
`default_nettype wire

// File: rtl/core/clipped_tile_rect_blit_rows_top.sv
// Top level of the clipped tile rectangle blit row command generator.
//
//  channel | dir | transaction                    | handshake
//  --------+-----+--------------------------------+-------------
//  req     | in  | one rectangle request          | valid/ready
//  cmd     | out | one visible row command        | valid/ready
//
// Flow: a request is clipped in the cycle it is taken, its first source
//   row base (one 8x10 multiply) is formed in the next, then it waits in a
//   two-entry queue. The back end sends one row per cycle while cmd is
//   ready, one command per visible row (1..DEST_ROWS); an empty clip
//   sends no row.
// Reset: arst_n clears the dirty mask, queue pointers and the row counter.
// Stalls: the front takes new requests while the back is still emitting
//   rows, until the queue and the front stage are full.
`default_nettype none
module clipped_tile_rect_blit_rows_top
	import ctrb_pkg::*;
#(
	parameter int DEST_COLS = DEST_COLS_DEF,  // 8..63
	parameter int DEST_ROWS = DEST_ROWS_DEF   // 8..64; COLS*ROWS <= 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ctrb_req_if.sink   req,
	ctrb_cmd_if.source cmd
);

	// descriptor hand-off front -> queue -> back
	desc_t push_desc, pop_desc;
	logic  push_valid, push_ready;
	logic  pop_valid, pop_ready;

	// clipping, dirty tracking, row base calculation
	ctrb_front #(
		.DEST_COLS (DEST_COLS),
		.DEST_ROWS (DEST_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_desc  (push_desc),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// decouples request intake from row emission
	ctrb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_desc  (push_desc),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_desc   (pop_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// row walker, doubles as the output register
	ctrb_back #(
		.DEST_COLS (DEST_COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_desc  (pop_desc),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.cmd       (cmd)
	);

endmodule
`default_nettype wire

// File: dv/clipped_tile_rect_blit_rows_top_tb.sv
// Testbench for the clipped tile rectangle blit row generator: random and directed requests,
// checked row by row against a behavioral predictor.
module clipped_tile_rect_blit_rows_top_tb;
	import ctrb_pkg::*;

	localparam int COLS = DEST_COLS_DEF;
	localparam int ROWS = DEST_ROWS_DEF;

	// request modes
	localparam logic MODE_ERASE = 1'b0;
	localparam logic MODE_COPY  = 1'b1;

	// random items per phase; the directed set rides in front of the first phase
	localparam int RAND_PER_PHASE = 80;
	// long receiver hold-off, starts once this many rows have been taken
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AFTER     = 60;
	// settle time after the last expected row: clip + multiply + queue stages
	localparam int DRAIN_CYCLES   = 40;
	// worst case is roughly 260 items x 24 rows at 12% receiver duty, plus holds
	localparam int CYCLE_LIMIT    = 600000;

	// one rectangle request as it goes over the req channel
	typedef struct {
		logic              mode;
		logic signed [8:0] dest_col;
		logic signed [8:0] dest_row;
		logic [7:0]        src_col;
		logic [7:0]        src_row;
		logic signed [8:0] req_cols;
		logic signed [8:0] req_rows;
		logic [7:0]        map_cols;
		logic [7:0]        map_rows;
		logic [2:0]        buffer_index;
	} rect_req_t;

	// one row command as it comes out of the cmd channel
	typedef struct {
		logic [SRC_W-1:0] src_offset;
		logic [DST_W-1:0] dst_offset;
		logic [LEN_W-1:0] run_length;
		logic             row_mode;
		logic [BUF_W-1:0] target_buffer;
		logic [MSK_W-1:0] dirty_mask;
		logic             last_row;
	} row_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ctrb_req_if req_ch();
	ctrb_cmd_if cmd_ch();

	clipped_tile_rect_blit_rows_top #(
		.DEST_COLS(COLS),
		.DEST_ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.cmd(cmd_ch)
	);

	always #10 clk = ~clk;

	rect_req_t  pending_rects[$];   // requests not yet offered
	row_cmd_t   rows_due[$];        // predicted row commands, oldest first
	rect_req_t  cur_rect;           // request currently on the req channel
	logic [7:0] dirty_seen;         // predictor's copy of the sticky dirty mask
	int         send_idle_pct;
	int         recv_idle_pct;
	int         fail_cnt;
	int         rows_taken;
	int         hold_left;
	bit         hold_done;
	int         cycle_cnt;

	// Predictor: resolve the size, clip against the destination and queue one
	// row command per visible row. Dirty bit is set even when nothing is visible.
	function automatic void clip_to_rows(rect_req_t q);
		int x, y, w, h, sc, sr;
		row_cmd_t c;
		w  = q.req_cols;
		h  = q.req_rows;
		sc = q.src_col;
		sr = q.src_row;
		// -1 means take the whole source map in that direction
		if (w == -1)
			w = q.map_cols;
		if (h == -1)
			h = q.map_rows;
		// left/top overhang eats into the size and pushes the source start along
		if (q.dest_col < 0) begin
			sc = sc - q.dest_col;
			w  = w + q.dest_col;
			x  = 0;
		end else begin
			x = q.dest_col;
		end
		if (x + w > COLS)
			w = COLS - x;
		if (q.dest_row < 0) begin
			sr = sr - q.dest_row;
			h  = h + q.dest_row;
			y  = 0;
		end else begin
			y = q.dest_row;
		end
		if (y + h > ROWS)
			h = ROWS - y;
		dirty_seen = dirty_seen | (8'd1 << q.buffer_index);
		// empty clip: no rows at all
		if (w <= 0 || h <= 0)
			return;
		for (int r = 0; r < h; r++) begin
			c.src_offset    = (q.mode == MODE_COPY) ? SRC_W'(int'(q.map_cols) * (sr + r) + sc)
				: '0;
			c.dst_offset    = DST_W'(x + (y + r) * COLS);
			c.run_length    = LEN_W'(w);
			c.row_mode      = q.mode;
			c.target_buffer = q.buffer_index;
			c.dirty_mask    = dirty_seen;
			c.last_row      = (r == h - 1);
			rows_due.push_back(c);
		end
	endfunction

	function automatic void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			fail_cnt++;
		end
	endfunction

	function automatic void queue_rect(int md, int dc, int dr, int sc, int sr, int rc, int rr,
		int mc, int mr, int bi);
		rect_req_t q;
		q.mode         = 1'(md);
		q.dest_col     = 9'(dc);
		q.dest_row     = 9'(dr);
		q.src_col      = 8'(sc);
		q.src_row      = 8'(sr);
		q.req_cols     = 9'(rc);
		q.req_rows     = 9'(rr);
		q.map_cols     = 8'(mc);
		q.map_rows     = 8'(mr);
		q.buffer_index = 3'(bi);
		pending_rects.push_back(q);
	endfunction

	// Mostly rectangles near the destination so that clipping on every edge gets
	// hit with real rows; a share of fully random noise covers every field bit.
	function automatic rect_req_t random_rect();
		rect_req_t q;
		q.mode         = 1'($urandom_range(1, 0));
		q.buffer_index = 3'($urandom_range(7, 0));
		q.src_col      = 8'($urandom);
		q.src_row      = 8'($urandom);
		if ($urandom_range(99, 0) < 15) begin
			q.dest_col = 9'($urandom);
			q.dest_row = 9'($urandom);
			q.req_cols = 9'($urandom);
			q.req_rows = 9'($urandom);
			q.map_cols = 8'($urandom);
			q.map_rows = 8'($urandom);
		end else begin
			q.dest_col = 9'(int'($urandom_range(72, 0)) - 40);
			q.dest_row = 9'(int'($urandom_range(56, 0)) - 30);
			q.map_cols = ($urandom_range(3, 0) == 0) ? 8'($urandom) : 8'($urandom_range(48, 1));
			q.map_rows = ($urandom_range(3, 0) == 0) ? 8'($urandom) : 8'($urandom_range(36, 1));
			q.req_cols = ($urandom_range(5, 0) == 0) ? -9'sd1 : 9'($urandom_range(40, 0));
			q.req_rows = ($urandom_range(5, 0) == 0) ? -9'sd1 : 9'($urandom_range(30, 0));
		end
		return q;
	endfunction

	// Driver: one transaction in flight on req; a new one is picked only once the
	// current one has been taken, so valid never drops while it is still pending.
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			busy = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				clip_to_rows(cur_rect);
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending_rects.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					cur_rect = pending_rects.pop_front();
					req_ch.mode         <= cur_rect.mode;
					req_ch.dest_col     <= cur_rect.dest_col;
					req_ch.dest_row     <= cur_rect.dest_row;
					req_ch.src_col      <= cur_rect.src_col;
					req_ch.src_row      <= cur_rect.src_row;
					req_ch.req_cols     <= cur_rect.req_cols;
					req_ch.req_rows     <= cur_rect.req_rows;
					req_ch.map_cols     <= cur_rect.map_cols;
					req_ch.map_rows     <= cur_rect.map_rows;
					req_ch.buffer_index <= cur_rect.buffer_index;
					req_ch.valid        <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every taken row command against the oldest prediction and
	// throttles ready. One long hold-off lets the block fill up and back-pressure req.
	always @(posedge clk or negedge arst_n) begin
		row_cmd_t e;
		if (!arst_n) begin
			cmd_ch.ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				rows_taken++;
				if (rows_due.size() == 0) begin
					$error("row command with nothing expected: dst_offset %0d",
						cmd_ch.dst_offset);
					fail_cnt++;
				end else begin
					e = rows_due.pop_front();
					check_field("src_offset", e.src_offset, cmd_ch.src_offset);
					check_field("dst_offset", e.dst_offset, cmd_ch.dst_offset);
					check_field("run_length", e.run_length, cmd_ch.run_length);
					check_field("row_mode", e.row_mode, cmd_ch.row_mode);
					check_field("target_buffer", e.target_buffer, cmd_ch.target_buffer);
					check_field("dirty_mask", e.dirty_mask, cmd_ch.dirty_mask);
					check_field("last_row", e.last_row, cmd_ch.last_row);
				end
			end
			if (!hold_done && rows_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				cmd_ch.ready <= 1'b0;
			end else begin
				cmd_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		req_ch.valid        = 1'b0;
		req_ch.mode         = 1'b0;
		req_ch.dest_col     = '0;
		req_ch.dest_row     = '0;
		req_ch.src_col      = '0;
		req_ch.src_row      = '0;
		req_ch.req_cols     = '0;
		req_ch.req_rows     = '0;
		req_ch.map_cols     = '0;
		req_ch.map_rows     = '0;
		req_ch.buffer_index = '0;
		cmd_ch.ready        = 1'b0;
		dirty_seen          = '0;
		fail_cnt            = 0;
		rows_taken          = 0;
		cycle_cnt           = 0;
		send_idle_pct       = 34;
		recv_idle_pct       = 88;

		// Directed set: edges of every field, both modes, every empty-clip flavor.
		// full source map that exactly fills the destination, copy then erase
		queue_rect(MODE_COPY, 0, 0, 0, 0, -1, -1, 32, 24, 0);
		queue_rect(MODE_ERASE, 0, 0, 0, 0, -1, -1, 32, 24, 1);
		// huge map, full size, cut at right and bottom edges
		queue_rect(MODE_COPY, 0, 0, 255, 255, -1, -1, 255, 255, 2);
		// most negative position: everything clipped away
		queue_rect(MODE_COPY, -256, -256, 0, 0, 255, 255, 255, 255, 3);
		// largest position: starts beyond the right and bottom edges
		queue_rect(MODE_ERASE, 255, 255, 0, 0, 255, 255, 255, 255, 4);
		// negative offsets on both axes move the source start
		queue_rect(MODE_COPY, -5, -3, 7, 9, 10, 10, 100, 100, 5);
		// zero width, and a negative width that is not the full-map marker
		queue_rect(MODE_COPY, 2, 2, 0, 0, 0, 5, 10, 10, 6);
		queue_rect(MODE_COPY, 2, 2, 0, 0, -2, 5, 10, 10, 7);
		// most negative height
		queue_rect(MODE_ERASE, 0, 0, 0, 0, 4, -256, 10, 10, 0);
		// bottom-right corner tile only
		queue_rect(MODE_COPY, 31, 23, 3, 4, 255, 255, 40, 40, 1);
		// just past the right edge, just past the bottom edge
		queue_rect(MODE_COPY, 32, 0, 0, 0, 4, 4, 8, 8, 2);
		queue_rect(MODE_COPY, 0, 24, 0, 0, 4, 4, 8, 8, 3);
		// empty source map with the full-map marker
		queue_rect(MODE_COPY, 0, 0, 0, 0, -1, -1, 0, 5, 4);
		queue_rect(MODE_COPY, 0, 0, 0, 0, -1, -1, 5, 0, 5);
		// largest source start in a 1x1 rectangle
		queue_rect(MODE_COPY, 10, 10, 255, 255, 1, 1, 255, 255, 6);
		// one column of overhang with a 33-wide map: exactly 32 visible
		queue_rect(MODE_COPY, -1, 0, 0, 0, -1, 3, 33, 10, 7);
		// deep overhang pushes the source start far past the map
		queue_rect(MODE_COPY, -255, -255, 255, 255, 300, 280, 255, 255, 0);
		// erase with an odd size in the middle
		queue_rect(MODE_ERASE, 13, 7, 200, 100, 5, 11, 1, 1, 6);
		// single row, full width
		queue_rect(MODE_COPY, 0, 23, 17, 0, -1, -1, 32, 1, 3);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < RAND_PER_PHASE; i++)
				pending_rects.push_back(random_rect());
			while (pending_rects.size() != 0)
				@(posedge clk);
		end

		// last request taken, every predicted row out, then a short settle
		while (req_ch.valid || rows_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
